[hw/rtl/olis_pkg.sv]
// Package for the ordered list insert/search unit.
// Holds request/response payload structs, request and status codes.
// No dependencies.
package olis_pkg;

    // request codes; anything above REQ_SEARCH acts as a search
    localparam logic [2:0] REQ_FRONT  = 3'd0;
    localparam logic [2:0] REQ_BACK   = 3'd1;
    localparam logic [2:0] REQ_AFTER  = 3'd2;
    localparam logic [2:0] REQ_BEFORE = 3'd3;
    localparam logic [2:0] REQ_SEARCH = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] match_value;
        logic signed [31:0] new_value;
    } olis_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [4:0] length;
    } olis_rsp_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } olis_seq_stat_t;

endpackage

[hw/rtl/olis_store.sv]
// Entry memory for the ordered list unit: one write port, one read port,
// registered read data. Depends on nothing.
module olis_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [31:0]       wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/olis_seq.sv]
// Sequencer for the ordered list unit: scans the entry memory with one
// shared comparator and moves entries one at a time. Uses olis_pkg.
module olis_seq #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  olis_pkg::olis_req_t     req,
    input  logic                    out_free,
    output olis_pkg::olis_seq_stat_t stat,
    output olis_pkg::olis_rsp_t     rsp,
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic [31:0]             wr_data,
    output logic [AW-1:0]           rd_addr,
    input  logic [31:0]             rd_data
);
    import olis_pkg::*;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_CMP      = 8'b0000_0100,
        S_DECIDE   = 8'b0000_1000,
        S_SHIFT_RD = 8'b0001_0000,
        S_SHIFT_WR = 8'b0010_0000,
        S_PLACE    = 8'b0100_0000,
        S_REPLY    = 8'b1000_0000
    } state_t;

    state_t          state_reg,  state_next;
    olis_req_t       req_reg,    req_next;
    logic [CW-1:0]   cnt_reg,    cnt_next;
    logic [CW-1:0]   idx_reg,    idx_next;
    logic [AW-1:0]   pos_reg,    pos_next;
    logic            hit_reg,    hit_next;
    logic [1:0]      status_reg, status_next;

    logic [CW-1:0]   idx_inc;
    logic [CW-1:0]   idx_dec;
    logic            full;
    logic            do_insert;
    logic [AW-1:0]   ins_pos;
    logic [CW+4:0]   len_ext;

    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);
    assign full    = (cnt_reg == CAP_C);

    // insert decision, taken once the scan has finished
    always_comb
    begin
        do_insert   = 1'b0;
        ins_pos     = '0;
        status_next = ST_DONE;
        unique case (req_reg.req_type)
            REQ_FRONT:
            begin
                if (full) status_next = ST_FULL;
                else      do_insert   = 1'b1;
                ins_pos = '0;
            end
            REQ_BACK:
            begin
                if (full) status_next = ST_FULL;
                else      do_insert   = 1'b1;
                ins_pos = cnt_reg[AW-1:0];
            end
            REQ_AFTER:
            begin
                if (!hit_reg)  status_next = ST_NOT_FOUND;
                else if (full) status_next = ST_FULL;
                else           do_insert   = 1'b1;
                ins_pos = pos_reg + AW'(1);
            end
            REQ_BEFORE:
            begin
                if (!hit_reg)  status_next = ST_NOT_FOUND;
                else if (full) status_next = ST_FULL;
                else           do_insert   = 1'b1;
                ins_pos = pos_reg;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        hit_next   = hit_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = rd_data;
        rd_addr    = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = (cnt_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_data == req_reg.match_value)
                begin
                    hit_next   = 1'b1;
                    pos_next   = idx_reg[AW-1:0];
                    state_next = S_DECIDE;
                end
                else if (idx_inc == cnt_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN;
                end
            end
            S_DECIDE:
            begin
                if (do_insert)
                begin
                    idx_next   = cnt_reg;
                    pos_next   = ins_pos;
                    state_next = (cnt_reg > CW'(ins_pos)) ? S_SHIFT_RD : S_PLACE;
                end
                else
                begin
                    state_next = S_REPLY;
                end
            end
            S_SHIFT_RD:
            begin
                rd_addr    = idx_dec[AW-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = rd_data;
                idx_next   = idx_dec;
                state_next = (idx_dec == CW'(pos_reg)) ? S_PLACE : S_SHIFT_RD;
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = req_reg.new_value;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        hit_reg <= hit_next;
        if (state_reg == S_DECIDE)
        begin
            status_reg <= status_next;
        end
    end

    assign len_ext     = (CW+5)'(cnt_reg);
    assign rsp.status  = status_reg;
    assign rsp.found   = hit_reg;
    assign rsp.length  = len_ext[4:0];
    assign stat.idle   = (state_reg == S_IDLE);
    assign stat.done   = (state_reg == S_REPLY) && out_free;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_C)
        else $error("entry count above capacity");

    a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE) |-> !full)
        else $error("insert into a full list");

    a_cnt_only_place: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_PLACE) |=> (cnt_reg == $past(cnt_reg)))
        else $error("entry count changed outside placement");

    a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> (idx_reg > CW'(pos_reg)))
        else $error("entry move at or below insertion point");

endmodule

[hw/rtl/ordered_list_insert_search_unit.sv]
// Top level of the ordered list insert/search unit.
// Instantiates olis_seq and olis_store; uses olis_pkg.

// Keeps an ordered list of up to CAPACITY signed 32-bit values in a
// single-port-read, single-port-write memory. Each request inserts
// new_value at the front, at the back, after or before the first entry
// equal to match_value, or searches for match_value (codes above search
// act as search). Every request returns one response: status (done, not
// found, full), found (match present before the request) and the length
// afterward. One request is worked at a time; req_stall is high from
// acceptance until the response is handed to the output register. A
// request is accepted, the shared comparator scans entries up to the
// first match, a decision step follows, an insert moves entries from
// the insertion point up back by one, then a placement step and a reply
// step that waits for a free output slot. The single registered read
// port makes each entry a read step and a compare or write step. The
// output register holds a response while the next request is accepted.
// No clearing pass after reset: only entries below the count are read.
module ordered_list_insert_search_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  olis_pkg::olis_req_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output olis_pkg::olis_rsp_t rsp_data
);
    import olis_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    olis_seq_stat_t  seq_stat;
    olis_rsp_t       seq_rsp;
    olis_rsp_t       rsp_reg;
    logic            rsp_valid_reg;
    logic            out_free;
    logic            start;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [31:0]     wr_data;
    logic [AW-1:0]   rd_addr;
    logic [31:0]     rd_data;

    // output slot is free when empty or being drained this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !seq_stat.idle;
    assign start     = req_valid && seq_stat.idle;

    olis_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req_data),
        .out_free (out_free),
        .stat     (seq_stat),
        .rsp      (seq_rsp),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    olis_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (seq_stat.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_stat.done)
        begin
            rsp_reg <= seq_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
